FILE: hdl/hnc_pkg.sv
// hnc_pkg: shared types and constants for the host name classifier.
// Used by hnc_char_decode, hnc_tracker and host_name_classifier_unit.
package hnc_pkg;

    // Byte codes
    localparam logic [7:0] CHAR_END       = 8'h00;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN    = 8'h2D;
    localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI  = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_LO  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI  = 8'h7A;

    // Dotted quad limits
    localparam logic [9:0] QUAD_MAX_VALUE  = 10'd255;
    localparam logic [2:0] QUAD_MAX_DIGITS = 3'd3;
    localparam logic [2:0] QUAD_LAST_DOTS  = 3'd3;

    // Saturation point of the length counters
    localparam logic [7:0] COUNT_SAT = 8'd255;

    // Configuration register indexes and reset values
    localparam logic CFG_MAX_NAME_LEN  = 1'b0;
    localparam logic CFG_MAX_LABEL_LEN = 1'b1;
    localparam logic [7:0] MAX_NAME_LEN_RST  = 8'd253;
    localparam logic [7:0] MAX_LABEL_LEN_RST = 8'd63;

    // Result codes
    typedef enum logic [1:0] {
        CLASS_INVALID = 2'd0,
        CLASS_IPV4    = 2'd1,
        CLASS_DOMAIN  = 2'd2
    } t_host_class;

    // One decoded byte
    typedef struct packed {
        logic       is_end;
        logic       is_dot;
        logic       is_digit;
        logic       is_letter;
        logic       is_hyphen;
        logic       is_other;
        logic [3:0] digit;
    } t_char_kind;

endpackage

FILE: hdl/hnc_char_decode.sv
// hnc_char_decode: sorts one name byte into end, dot, digit, letter,
// hyphen or other. Pure combinational; depends on hnc_pkg.
module hnc_char_decode
    import hnc_pkg::*;
(
    input  logic [7:0] i_char,
    output t_char_kind o_kind
);

    always_comb begin
        o_kind       = '0;
        o_kind.digit = 4'(i_char - CHAR_DIGIT_LO);
        case (i_char) inside
            CHAR_END:                       o_kind.is_end    = 1'b1;
            CHAR_DOT:                       o_kind.is_dot    = 1'b1;
            CHAR_HYPHEN:                    o_kind.is_hyphen = 1'b1;
            [CHAR_DIGIT_LO:CHAR_DIGIT_HI]:  o_kind.is_digit  = 1'b1;
            [CHAR_UPPER_LO:CHAR_UPPER_HI],
            [CHAR_LOWER_LO:CHAR_LOWER_HI]:  o_kind.is_letter = 1'b1;
            default:                        o_kind.is_other  = 1'b1;
        endcase
    end

endmodule

FILE: hdl/hnc_tracker.sv
// hnc_tracker: running flags and counters of the name being received and
// the class of the name at its end byte. Depends on hnc_pkg.
module hnc_tracker
    import hnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_char_kind  i_kind,
    input  logic [7:0]  i_max_name_len,
    input  logic [7:0]  i_max_label_len,
    output t_host_class o_host_class,
    output logic        o_idle
);

    logic [7:0] r_name_len,   n_name_len;
    logic [2:0] r_part_cnt,   n_part_cnt;
    logic [9:0] r_part_val,   n_part_val;
    logic [2:0] r_digit_cnt,  n_digit_cnt;
    logic       r_quad_ok,    n_quad_ok;
    logic       r_seen_letter, n_seen_letter;
    logic [7:0] r_label_len,  n_label_len;
    logic       r_label_start, n_label_start;
    logic       r_prev_hyphen, n_prev_hyphen;
    logic       r_domain_ok,  n_domain_ok;
    logic       r_bad_char,   n_bad_char;

    logic label_bad_end;
    logic quad_final;
    logic domain_final;
    logic label_byte;

    // Class of the name as it stands, used at the end byte
    assign label_bad_end = (r_label_len == '0) || r_prev_hyphen;
    assign quad_final    = r_quad_ok && (r_part_cnt == QUAD_LAST_DOTS) &&
                           (r_digit_cnt != '0) && (r_part_val <= QUAD_MAX_VALUE);
    assign domain_final  = r_seen_letter && r_domain_ok && !label_bad_end &&
                           !r_bad_char;

    always_comb begin
        if (r_name_len == '0) begin
            o_host_class = CLASS_INVALID;
        end else if (quad_final) begin
            o_host_class = CLASS_IPV4;
        end else if (domain_final) begin
            o_host_class = CLASS_DOMAIN;
        end else begin
            o_host_class = CLASS_INVALID;
        end
    end

    assign o_idle = (r_name_len == '0);

    assign label_byte = i_kind.is_digit || i_kind.is_letter || i_kind.is_hyphen;

    // Next state for one byte
    always_comb begin
        n_name_len    = r_name_len;
        n_part_cnt    = r_part_cnt;
        n_part_val    = r_part_val;
        n_digit_cnt   = r_digit_cnt;
        n_quad_ok     = r_quad_ok;
        n_seen_letter = r_seen_letter;
        n_label_len   = r_label_len;
        n_label_start = r_label_start;
        n_prev_hyphen = r_prev_hyphen;
        n_domain_ok   = r_domain_ok;
        n_bad_char    = r_bad_char;

        if (i_kind.is_end) begin
            // end of name: back to the empty state
            n_name_len    = '0;
            n_part_cnt    = '0;
            n_part_val    = '0;
            n_digit_cnt   = '0;
            n_quad_ok     = 1'b1;
            n_seen_letter = 1'b0;
            n_label_len   = '0;
            n_label_start = 1'b1;
            n_prev_hyphen = 1'b0;
            n_domain_ok   = 1'b1;
            n_bad_char    = 1'b0;
        end else begin
            // total length
            if (r_name_len >= i_max_name_len) begin
                n_domain_ok = 1'b0;
            end
            if (r_name_len != COUNT_SAT) begin
                n_name_len = r_name_len + 8'd1;
            end

            // label length and label start, for label bytes
            if (label_byte) begin
                if (r_label_len >= i_max_label_len) begin
                    n_domain_ok = 1'b0;
                end
                if (r_label_len != COUNT_SAT) begin
                    n_label_len = r_label_len + 8'd1;
                end
                n_label_start = 1'b0;
                n_prev_hyphen = i_kind.is_hyphen;
            end

            if (i_kind.is_dot) begin
                if ((r_digit_cnt == '0) || (r_part_val > QUAD_MAX_VALUE) ||
                    (r_part_cnt >= QUAD_LAST_DOTS)) begin
                    n_quad_ok = 1'b0;
                end else begin
                    n_part_cnt = r_part_cnt + 3'd1;
                end
                n_part_val  = '0;
                n_digit_cnt = '0;
                if (label_bad_end) begin
                    n_domain_ok = 1'b0;
                end
                n_label_len   = '0;
                n_label_start = 1'b1;
                n_prev_hyphen = 1'b0;
            end

            if (i_kind.is_digit) begin
                if (r_digit_cnt >= QUAD_MAX_DIGITS) begin
                    n_quad_ok = 1'b0;
                end else begin
                    // value * 10 + digit, at most 999 here
                    n_part_val  = {r_part_val[6:0], 3'b000} + {r_part_val[8:0], 1'b0}
                                  + {6'd0, i_kind.digit};
                    n_digit_cnt = r_digit_cnt + 3'd1;
                end
            end

            if (i_kind.is_letter) begin
                n_quad_ok     = 1'b0;
                n_seen_letter = 1'b1;
            end

            if (i_kind.is_hyphen) begin
                n_quad_ok = 1'b0;
                if (r_label_start) begin
                    n_domain_ok = 1'b0;
                end
            end

            if (i_kind.is_other) begin
                n_quad_ok  = 1'b0;
                n_bad_char = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len    <= '0;
            r_part_cnt    <= '0;
            r_part_val    <= '0;
            r_digit_cnt   <= '0;
            r_quad_ok     <= 1'b1;
            r_seen_letter <= 1'b0;
            r_label_len   <= '0;
            r_label_start <= 1'b1;
            r_prev_hyphen <= 1'b0;
            r_domain_ok   <= 1'b1;
            r_bad_char    <= 1'b0;
        end else if (i_step) begin
            r_name_len    <= n_name_len;
            r_part_cnt    <= n_part_cnt;
            r_part_val    <= n_part_val;
            r_digit_cnt   <= n_digit_cnt;
            r_quad_ok     <= n_quad_ok;
            r_seen_letter <= n_seen_letter;
            r_label_len   <= n_label_len;
            r_label_start <= n_label_start;
            r_prev_hyphen <= n_prev_hyphen;
            r_domain_ok   <= n_domain_ok;
            r_bad_char    <= n_bad_char;
        end
    end

endmodule

FILE: hdl/host_name_classifier_unit.sv
// host_name_classifier_unit: top level of the host name classifier.
// Depends on hnc_pkg, hnc_char_decode and hnc_tracker.
//
// Usage:
//   Input channel (i_valid / o_stall / i_char_code) carries one byte of a
//   host name per beat. A zero byte ends the name and produces exactly one
//   result beat on the output channel (o_valid / i_stall / o_host_class):
//   0 invalid, 1 IPv4 dotted quad, 2 domain name. Other bytes give no beat.
//   A byte goes into an input register, is folded into the running state
//   by one level of short logic, and an end byte loads the result register.
//   Throughput: one byte per cycle while o_stall is low.
//   The write port (i_cfg_we / i_cfg_index / i_cfg_data) sets the name
//   length limit (index 0, reset 253) and the label length limit (index 1,
//   reset 63); write only while no name is in progress.
//   Synchronous reset clears the running state and the valid flags of both
//   data path registers, and loads the limits with their reset values.
//   When the receiver stalls with a result waiting, non-end bytes still
//   flow; an end byte waits in the input register and o_stall rises.
module host_name_classifier_unit
    import hnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_host_class,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_out_valid;
    t_host_class r_out_class;
    logic [7:0]  r_max_name_len;
    logic [7:0]  r_max_label_len;

    t_char_kind  kind;
    t_host_class trk_class;
    logic        trk_idle;
    logic        out_free;
    logic        advance;
    logic        in_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_len  <= MAX_NAME_LEN_RST;
            r_max_label_len <= MAX_LABEL_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_NAME_LEN:  r_max_name_len  <= i_cfg_data;
                CFG_MAX_LABEL_LEN: r_max_label_len <= i_cfg_data;
                default:           r_max_name_len  <= r_max_name_len;
            endcase
        end
    end

    // Decode of the registered byte
    hnc_char_decode u_decode (
        .i_char (r_in_char),
        .o_kind (kind)
    );

    // Handshake: an end byte needs the result register free
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!kind.is_end || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_code;
        end
    end

    // Running state
    hnc_tracker u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_kind          (kind),
        .i_max_name_len  (r_max_name_len),
        .i_max_label_len (r_max_label_len),
        .o_host_class    (trk_class),
        .o_idle          (trk_idle)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && kind.is_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && kind.is_end) begin
            r_out_class <= trk_class;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_host_class = r_out_class;

`ifndef ASSERT_OFF
    // An accepted end byte always lands in the result register
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && kind.is_end) |=> r_out_valid)
        else $error("end byte did not produce a result");

    // The running state is empty right after an end byte
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && kind.is_end) |=> trk_idle)
        else $error("running state not cleared after end byte");

    // Only an end byte facing a blocked result register stalls the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && kind.is_end && r_out_valid && i_stall))
        else $error("input stalled without cause");

    // Code 3 is never produced
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_class != 2'd3))
        else $error("result class out of range");
`endif

endmodule

FILE: test/tb.sv
// tb: self-checking testbench for host_name_classifier_unit.
// Depends on hnc_pkg and the RTL of the classifier; drives byte beats and limit writes,
// predicts each class code and compares every result beat against the prediction.
module tb;
    import hnc_pkg::*;

    localparam int LONG_HOLD = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_code;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_host_class;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    // Idle controls for the driving processes, and the count of bytes sent
    bit send_gaps;
    bit resp_gaps;
    bit hold_long;
    int bytes_sent;

    logic [7:0] name_buf[$];

    // Tracks one name in flight and keeps the class codes still owed by the block
    class host_class_scoreboard;
        logic [7:0]  name_lim;
        logic [7:0]  label_lim;
        logic [7:0]  name_len;
        logic [7:0]  lbl_count;
        logic [2:0]  dots;
        logic [9:0]  part_val;
        logic [2:0]  digits;
        bit          quad_ok;
        bit          letter_seen;
        bit          lbl_first;
        bit          last_hyphen;
        bit          domain_ok;
        bit          bad_seen;
        t_host_class class_q[$];
        int          errors;

        function new();
            name_lim  = MAX_NAME_LEN_RST;
            label_lim = MAX_LABEL_LEN_RST;
            errors    = 0;
            clear_name();
        endfunction

        function void clear_name();
            name_len    = '0;
            lbl_count   = '0;
            dots        = '0;
            part_val    = '0;
            digits      = '0;
            quad_ok     = 1'b1;
            letter_seen = 1'b0;
            lbl_first   = 1'b1;
            last_hyphen = 1'b0;
            domain_ok   = 1'b1;
            bad_seen    = 1'b0;
        endfunction

        function void set_limit(logic idx, logic [7:0] v);
            if (idx == CFG_MAX_NAME_LEN) begin
                name_lim = v;
            end else begin
                label_lim = v;
            end
        endfunction

        // Byte inside a label: count it and check the label limit
        function void label_char();
            if (lbl_count >= label_lim) domain_ok = 1'b0;
            if (lbl_count != COUNT_SAT) lbl_count++;
            lbl_first = 1'b0;
        endfunction

        function void close_label();
            if (lbl_count == 0 || last_hyphen) domain_ok = 1'b0;
            lbl_count   = '0;
            lbl_first   = 1'b1;
            last_hyphen = 1'b0;
        endfunction

        function void note_byte(logic [7:0] c);
            t_host_class cls;
            bit          is_num;
            bit          is_alpha;
            is_num   = (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI);
            is_alpha = (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
                       (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI);
            if (c == CHAR_END) begin
                cls = CLASS_INVALID;
                if (name_len != 0) begin
                    close_label();
                    if (quad_ok && dots == QUAD_LAST_DOTS && digits != 0 &&
                        part_val <= QUAD_MAX_VALUE) begin
                        cls = CLASS_IPV4;
                    end else if (letter_seen && domain_ok && !bad_seen) begin
                        cls = CLASS_DOMAIN;
                    end
                end
                class_q.push_back(cls);
                clear_name();
            end else begin
                if (name_len >= name_lim) domain_ok = 1'b0;
                if (name_len != COUNT_SAT) name_len++;
                if (c == CHAR_DOT) begin
                    if (digits == 0 || part_val > QUAD_MAX_VALUE || dots >= QUAD_LAST_DOTS) begin
                        quad_ok = 1'b0;
                    end else begin
                        dots++;
                    end
                    part_val = '0;
                    digits   = '0;
                    close_label();
                end else if (is_num) begin
                    if (digits >= QUAD_MAX_DIGITS) begin
                        quad_ok = 1'b0;
                    end else begin
                        part_val = part_val * 10 + c[3:0];
                        digits++;
                    end
                    label_char();
                    last_hyphen = 1'b0;
                end else if (is_alpha) begin
                    quad_ok     = 1'b0;
                    letter_seen = 1'b1;
                    label_char();
                    last_hyphen = 1'b0;
                end else if (c == CHAR_HYPHEN) begin
                    quad_ok = 1'b0;
                    if (lbl_first) domain_ok = 1'b0;
                    label_char();
                    last_hyphen = 1'b1;
                end else begin
                    quad_ok  = 1'b0;
                    bad_seen = 1'b1;
                end
            end
        endfunction

        function void check_result(logic [1:0] got);
            t_host_class exp;
            if (class_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %0d", $time, got);
                errors++;
            end else begin
                exp = class_q.pop_front();
                if (got !== exp) begin
                    $display("%0t: host class mismatch, expected %0d actual %0d",
                             $time, exp, got);
                    errors++;
                end
            end
        endfunction
    endclass

    host_class_scoreboard sb;

    host_name_classifier_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_host_class (o_host_class),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Byte builders for the name under construction
    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CHAR_UPPER_LO + 8'(r) : CHAR_LOWER_LO + 8'(r - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_DIGIT_LO + 8'($urandom_range(0, 9));
    endfunction

    // Any byte that is not a letter, digit, dot, hyphen or the end byte
    function automatic logic [7:0] pick_stray();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while ((c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
                   (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
                   (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
                   c == CHAR_DOT || c == CHAR_HYPHEN);
        return c;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endfunction

    function automatic void push_letters(int n);
        repeat (n) name_buf.push_back(pick_letter());
    endfunction

    // Label of well-formed content; hyphens only inside
    function automatic void push_label(int len, bit letter_first);
        for (int i = 0; i < len; i++) begin
            if (i == 0 && letter_first) begin
                name_buf.push_back(pick_letter());
            end else if (i != 0 && i != len - 1 && $urandom_range(0, 4) == 0) begin
                name_buf.push_back(CHAR_HYPHEN);
            end else begin
                name_buf.push_back($urandom_range(0, 2) == 0 ? pick_digit() : pick_letter());
            end
        end
    endfunction

    function automatic void push_decimal(int val, int width);
        string s;
        s = $sformatf("%0d", val);
        while (s.len() < width) s = {"0", s};
        push_text(s);
    endfunction

    // Dotted quad; mode 0 is well formed, others break it in one way
    function automatic void make_quad(int mode);
        int n_parts;
        int bad_idx;
        int v;
        int w;
        n_parts = (mode == 1) ? 3 : (mode == 2) ? 5 : 4;
        bad_idx = $urandom_range(0, n_parts - 1);
        for (int i = 0; i < n_parts; i++) begin
            if (i > 0) name_buf.push_back(CHAR_DOT);
            if (!(mode == 3 && i == bad_idx)) begin
                if ($urandom_range(0, 3) == 0) begin
                    v = $urandom_range(0, 1) ? 255 : 0;
                end else begin
                    v = $urandom_range(0, 255);
                end
                if (mode == 4 && i == bad_idx) v = $urandom_range(256, 999);
                w = $urandom_range(1, 3);
                if (mode == 5 && i == bad_idx) w = $urandom_range(4, 6);
                push_decimal(v, w);
                if (mode == 6 && i == bad_idx) begin
                    case ($urandom_range(0, 2))
                        0: name_buf.push_back(pick_letter());
                        1: name_buf.push_back(CHAR_HYPHEN);
                        default: name_buf.push_back(pick_stray());
                    endcase
                end
            end
        end
        if (mode == 7) name_buf.push_back(CHAR_DOT);
        if (mode == 8) name_buf.push_front(CHAR_DOT);
    endfunction

    // Domain name; mode 0 is well formed, others break or stretch it
    function automatic void make_domain(int mode);
        int n_labels;
        int bad_idx;
        int len;
        int r;
        int lim;
        lim      = int'(sb.label_lim);
        n_labels = $urandom_range(1, 4);
        bad_idx  = $urandom_range(0, n_labels - 1);
        for (int i = 0; i < n_labels; i++) begin
            if (i > 0) name_buf.push_back(CHAR_DOT);
            r   = $urandom_range(0, 19);
            len = (r == 0) ? lim : $urandom_range(1, 8);
            if (mode == 7 && i == bad_idx) len = lim + 1;
            if (mode == 1 && i == bad_idx) name_buf.push_back(CHAR_HYPHEN);
            if (mode == 5 && i == bad_idx) begin
                repeat ($urandom_range(4, 20)) name_buf.push_back(pick_digit());
            end else begin
                push_label(len, i == 0);
            end
            if (mode == 2 && i == bad_idx) name_buf.push_back(CHAR_HYPHEN);
            if (mode == 3 && i == bad_idx) name_buf.push_back(CHAR_DOT);
        end
        if (mode == 4) name_buf.insert($urandom_range(0, name_buf.size()), pick_stray());
        if (mode == 6) name_buf.push_back(CHAR_DOT);
    endfunction

    function automatic void make_noise();
        repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    // One byte beat on the input channel, with an optional gap in front
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            gap         = $urandom_range(1, 17);
            i_valid     = 1'b0;
            i_char_code = 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_char_code = c;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(c);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_name();
        foreach (name_buf[i]) send_byte(name_buf[i]);
        send_byte(CHAR_END);
        name_buf.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_name();
    endtask

    // Stop offering beats and wait until every class code has come back
    task automatic drain_results();
        i_valid = 1'b0;
        while (sb.class_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [7:0] name_max, input logic [7:0] label_max);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_MAX_NAME_LEN;
        i_cfg_data  = name_max;
        @(negedge i_clk);
        i_cfg_index = CFG_MAX_LABEL_LEN;
        i_cfg_data  = label_max;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_limit(CFG_MAX_NAME_LEN, name_max);
        sb.set_limit(CFG_MAX_LABEL_LEN, label_max);
    endtask

    // Random names until the byte budget is spent
    task automatic run_names(input int budget);
        int target;
        int pick;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                make_quad(0);
            end else if (pick < 42) begin
                make_quad($urandom_range(1, 8));
            end else if (pick < 72) begin
                make_domain(0);
            end else if (pick < 86) begin
                make_domain($urandom_range(1, 7));
            end else if (pick < 96) begin
                make_noise();
            end else begin
                name_buf.delete();
            end
            send_name();
        end
    endtask

    string plain_cases[] = '{
        "", "0.0.0.0", "255.255.255.255", "256.1.1.1", "999.1.1.1", "1.2.3",
        "1.2.3.4.", "1..2.3", "1.2.3.4.5", "001.02.3.4", "0001.2.3.4", "a",
        "Zz-9.mail-Host.ORG", "-ab", "ab-", "a.-b", "a..b", ".ab", "a b", "a_b",
        "1234567890.com", "1.2.3.x"
    };

    // Result side: accepted beats go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_host_class);
    end

    // Receiver stalls: random bursts, plus one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (resp_gaps && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_stall = 1'b0;
        end
    end

    initial begin
        #2000000;
        $display("host_name_classifier_unit verification failed");
        $finish;
    end

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_char_code = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_NAME_LEN;
        i_cfg_data  = 8'h00;
        send_gaps   = 1'b1;
        resp_gaps   = 1'b1;
        hold_long   = 1'b0;
        bytes_sent  = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default limits: quad edges, label rules, stray bytes
        foreach (plain_cases[i]) send_text(plain_cases[i]);
        name_buf = '{8'hFF, 8'h80, CHAR_DOT, 8'h7F, 8'h01};
        send_name();

        // Zero limits: no domain fits, quads still pass
        write_limits(8'd0, 8'd0);
        send_text("a");
        send_text("1.2.3.4");
        send_text("ab.c");

        // Tightest nonzero limits
        write_limits(8'd1, 8'd1);
        send_text("a");
        send_text("a.b");
        send_text("ab");
        send_text("1.2.3.4");

        // Widest limits, one name past counter saturation
        write_limits(8'd255, 8'd255);
        push_letters(256);
        send_name();

        // Small random limits, with one long receiver hold
        write_limits(8'($urandom_range(6, 40)), 8'($urandom_range(2, 12)));
        hold_long = 1'b1;
        run_names(30);

        write_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 40)));
        run_names(25);

        // Last stretch at full rate
        write_limits(MAX_NAME_LEN_RST, MAX_LABEL_LEN_RST);
        send_gaps = 1'b0;
        resp_gaps = 1'b0;
        run_names(30);

        drain_results();
        if (sb.errors == 0 && sb.class_q.size() == 0) begin
            $display("host_name_classifier_unit verification clean");
        end else begin
            $display("host_name_classifier_unit verification failed");
        end
        $finish;
    end

endmodule
